[hdl/pitch_contour_generator_core_defines.svh]
// Assertion macros for the pitch contour generator.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef PITCH_CONTOUR_GENERATOR_CORE_DEFINES_SVH
`define PITCH_CONTOUR_GENERATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge out of reset.
`define PCG_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pcg check failed");
// Antecedent implies consequent in the next cycle.
`define PCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcg check failed");
`else
`define PCG_ASSERT(label, cond)
`define PCG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/pcg_pkg.sv]
// Shared types and constants of the pitch contour generator.
// No dependencies; used by pcg_mul and pitch_contour_generator_core.
package pcg_pkg;
    localparam int FREQ_W = 24;
    localparam int DUR_W  = 10;
    localparam int OFF_W  = 11;
    localparam int NUM_W  = 34;
    localparam int V_W    = 26;
    localparam int SEM_W  = 16;
    localparam int MUL_W  = 32;
    localparam logic [20:0] LOG2_REF_Q16 = 21'd1181703;

    // Operand pair presented to the shared multiplier.
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;
endpackage

[hdl/pcg_mul.sv]
// Shared registered multiplier of the pitch contour generator.
// Depends on pcg_pkg for the operand struct.
module pcg_mul
    import pcg_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic [2*MUL_W-1:0] o_prod
);
    logic [2*MUL_W-1:0] r_prod;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;
endmodule

[hdl/pitch_contour_generator_core.sv]
// Top level of the pitch contour generator: sequencer, divider, log unit.
// Depends on pcg_pkg, pcg_mul and pitch_contour_generator_core_defines.svh.
//
// Usage: control points of one syllable enter on the input channel
// (i_valid / o_stall) with frequency (Q16.8 Hz), duration in ms and a final
// mark. Smoothed pitch samples in semitones from middle C (Q8.8) leave on
// the output channel (o_valid / i_stall), one request each, with a final
// sample mark and a clamped-duration flag.
// A point is accepted when i_valid is high and o_stall is low; o_stall is
// high for the whole time the block works on a point. Each raw sample passes
// through the multiplier states S_MUL1 to S_MUL3, 34 divider steps (one
// quotient bit per cycle), a filtering step, normalization and repeated
// squaring on the shared multiplier. A point yields up to 30 samples per
// 600 ms segment (two segments on the final point).
// A finished sample waits in the output register; while the receiver holds
// i_stall high the sequencer holds the next finished sample until it frees.
// Synchronous reset clears the syllable state and the output valid.
module pitch_contour_generator_core
    import pcg_pkg::*;
#(
    parameter int MAX_SEGMENT_MS   = 600,
    parameter int SAMPLE_PERIOD_MS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [FREQ_W-1:0]       i_freq_hz_q8,
    input  logic [DUR_W-1:0]        i_duration_ms,
    input  logic                    i_last_point,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SEM_W-1:0] o_semitone_q8,
    output logic                    o_last_sample,
    output logic                    o_clamped
);
    `include "pitch_contour_generator_core_defines.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEG    = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_MUL3   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_NORM   = 4'd7;
    localparam logic [3:0] S_SQ_MUL = 4'd8;
    localparam logic [3:0] S_SQ_ADJ = 4'd9;
    localparam logic [3:0] S_ROUND  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;

    localparam logic [DUR_W-1:0] MAX_D  = DUR_W'(MAX_SEGMENT_MS);
    localparam logic [OFF_W-1:0] PERIOD = OFF_W'(SAMPLE_PERIOD_MS);

    logic [3:0]              r_state;
    // Syllable state.
    logic [FREQ_W-1:0]       r_prev_freq;
    logic [DUR_W-1:0]        r_prev_dur;
    logic                    r_have_prev;
    logic [OFF_W-1:0]        r_off;
    logic [FREQ_W-1:0]       r_older;
    logic [FREQ_W-1:0]       r_pending;
    logic [1:0]              r_seen;
    logic                    r_clamp_seen;
    // Current point and segment.
    logic [FREQ_W-1:0]       r_f;
    logic [DUR_W-1:0]        r_d;
    logic                    r_last;
    logic                    r_phase;
    logic [FREQ_W-1:0]       r_f1;
    logic [FREQ_W-1:0]       r_f2;
    logic [DUR_W-1:0]        r_seg_d;
    // Arithmetic datapath.
    logic [NUM_W-1:0]        r_acc;
    logic [NUM_W-1:0]        r_num;
    logic [DUR_W-1:0]        r_rem;
    logic [5:0]              r_cnt;
    logic [V_W-1:0]          r_v;
    logic [4:0]              r_n;
    logic [30:0]             r_m;
    logic [15:0]             r_frac;
    logic                    r_end_cont;
    logic                    r_out_last;
    logic signed [SEM_W-1:0] r_res;
    // Output register.
    logic                    r_ov;
    logic signed [SEM_W-1:0] r_out_sem;
    logic                    r_out_lastq;
    logic                    r_out_clamp;

    t_mul_req           mul_req;
    logic [2*MUL_W-1:0] mul_prod;
    logic               in_take;
    logic               out_free;
    logic               emit_take;
    logic [DUR_W:0]     div_try;
    logic [DUR_W:0]     div_sub;
    logic [OFF_W-1:0]   seg_left;
    logic [31:0]        sq_hi;
    logic [FREQ_W-1:0]  quot;
    logic signed [22:0] lg_diff;
    logic signed [26:0] lg_scaled;
    logic signed [18:0] lg_round;
    logic signed [SEM_W-1:0] sat_res;

    assign in_take   = i_valid && !o_stall;
    assign out_free  = !r_ov || !i_stall;
    assign emit_take = (r_state == S_EMIT) && out_free;
    assign o_stall   = (r_state != S_IDLE);

    // Shared multiplier operand selection.
    assign seg_left = OFF_W'({1'b0, r_seg_d}) - r_off;
    always_comb begin
        mul_req = '0;
        case (r_state)
            S_MUL1: begin
                mul_req.a = MUL_W'(r_f1);
                mul_req.b = MUL_W'(seg_left);
            end
            S_MUL2: begin
                mul_req.a = MUL_W'(r_f2);
                mul_req.b = MUL_W'(r_off);
            end
            S_SQ_MUL: begin
                mul_req.a = MUL_W'(r_m);
                mul_req.b = MUL_W'(r_m);
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    pcg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // One restoring division step.
    assign div_try = {r_rem, r_num[NUM_W-1]};
    assign div_sub = div_try - {1'b0, r_seg_d};
    assign quot    = r_num[FREQ_W-1:0];

    // Squared mantissa back in Q30.
    assign sq_hi = mul_prod[61:30];

    // Semitone scaling: 12 * (log2 - ref) rounded to Q8.8, then saturated.
    assign lg_diff   = $signed({2'b00, r_n, r_frac}) - $signed({2'b00, LOG2_REF_Q16});
    assign lg_scaled = (27'(lg_diff) <<< 3) + (27'(lg_diff) <<< 2) + 27'sd128;
    assign lg_round  = 19'(lg_scaled >>> 8);
    always_comb begin
        if (lg_round > 19'sd32767) begin
            sat_res = 16'sh7fff;
        end else if (lg_round < -19'sd32768) begin
            sat_res = 16'sh8000;
        end else begin
            sat_res = lg_round[SEM_W-1:0];
        end
    end

    // Output register: loads a finished sample and clears once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_take) begin
            r_ov        <= 1'b1;
            r_out_sem   <= r_res;
            r_out_lastq <= r_out_last;
            r_out_clamp <= r_clamp_seen;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_freq  <= '0;
            r_prev_dur   <= '0;
            r_have_prev  <= 1'b0;
            r_off        <= '0;
            r_older      <= '0;
            r_pending    <= '0;
            r_seen       <= '0;
            r_clamp_seen <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_f     <= i_freq_hz_q8;
                        r_last  <= i_last_point;
                        r_phase <= 1'b0;
                        if (i_duration_ms > MAX_D) begin
                            r_d          <= MAX_D;
                            r_clamp_seen <= 1'b1;
                        end else begin
                            r_d <= i_duration_ms;
                        end
                        r_f1    <= r_prev_freq;
                        r_seg_d <= r_prev_dur;
                        r_f2    <= i_freq_hz_q8;
                        r_state <= r_have_prev ? S_SEG : S_NEXT;
                    end
                end
                S_SEG: begin
                    if (r_off < OFF_W'({1'b0, r_seg_d})) begin
                        r_state <= S_MUL1;
                    end else begin
                        r_off   <= r_off - OFF_W'({1'b0, r_seg_d});
                        r_state <= S_NEXT;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= mul_prod[NUM_W-1:0] + NUM_W'(r_seg_d >> 1);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_num   <= r_acc + mul_prod[NUM_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= 6'(NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!div_sub[DUR_W]) begin
                        r_rem <= div_sub[DUR_W-1:0];
                        r_num <= {r_num[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= div_try[DUR_W-1:0];
                        r_num <= {r_num[NUM_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_PUSH: begin
                    r_pending  <= quot;
                    r_older    <= r_pending;
                    r_out_last <= 1'b0;
                    r_end_cont <= 1'b0;
                    r_n        <= 5'(V_W - 1);
                    if (r_seen == 2'd0) begin
                        r_seen  <= 2'd1;
                        r_off   <= r_off + PERIOD;
                        r_state <= S_SEG;
                    end else if (r_seen == 2'd1) begin
                        r_v     <= {r_pending, 2'b00};
                        r_seen  <= 2'd2;
                        r_state <= S_NORM;
                    end else begin
                        r_v     <= V_W'(r_older) + {1'b0, r_pending, 1'b0} + V_W'(quot);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_v < V_W'(1024)) begin
                        r_res   <= 16'sh8000;
                        r_state <= S_EMIT;
                    end else if (r_v[V_W-1]) begin
                        r_m     <= {r_v, 5'b00000};
                        r_frac  <= '0;
                        r_cnt   <= 6'd15;
                        r_state <= S_SQ_MUL;
                    end else begin
                        r_v <= {r_v[V_W-2:0], 1'b0};
                        r_n <= r_n - 5'd1;
                    end
                end
                S_SQ_MUL: begin
                    r_state <= S_SQ_ADJ;
                end
                S_SQ_ADJ: begin
                    if (sq_hi[31]) begin
                        r_m    <= sq_hi[31:1];
                        r_frac <= r_frac | (16'd1 << r_cnt[3:0]);
                    end else begin
                        r_m <= sq_hi[30:0];
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt   <= r_cnt - 6'd1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_ROUND: begin
                    r_res   <= sat_res;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_end_cont) begin
                            r_have_prev  <= 1'b0;
                            r_off        <= '0;
                            r_seen       <= '0;
                            r_clamp_seen <= 1'b0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_off   <= r_off + PERIOD;
                            r_state <= S_SEG;
                        end
                    end
                end
                S_NEXT: begin
                    if (!r_phase) begin
                        r_prev_freq <= r_f;
                        r_prev_dur  <= r_d;
                        r_have_prev <= 1'b1;
                        if (r_last) begin
                            r_f1    <= r_f;
                            r_f2    <= r_f;
                            r_seg_d <= r_d;
                            r_phase <= 1'b1;
                            r_state <= S_SEG;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_seen != 2'd0) begin
                        r_v        <= {r_pending, 2'b00};
                        r_out_last <= 1'b1;
                        r_end_cont <= 1'b1;
                        r_n        <= 5'(V_W - 1);
                        r_state    <= S_NORM;
                    end else begin
                        r_have_prev  <= 1'b0;
                        r_off        <= '0;
                        r_seen       <= '0;
                        r_clamp_seen <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_semitone_q8 = r_out_sem;
    assign o_last_sample = r_out_lastq;
    assign o_clamped     = r_out_clamp;

    // The division remainder always stays below the divisor.
    `PCG_ASSERT(a_rem_below_div, (r_state != S_DIV) || (r_rem < r_seg_d))
    // The sample counter saturates at two.
    `PCG_ASSERT(a_seen_range, r_seen != 2'd3)
    // The squaring mantissa is normalized to Q30.
    `PCG_ASSERT(a_mant_norm, (r_state != S_SQ_MUL) || r_m[30])
    // An accepted point always starts the sequencer.
    `PCG_ASSERT_NEXT(a_take_starts, in_take, r_state != S_IDLE)
    // Between segments the stored offset stays under one sample period.
    `PCG_ASSERT(a_off_idle, (r_state != S_IDLE) || (r_off < PERIOD))
endmodule
